[rtl/core/hpt_pkg.sv]
// Package: widths, register indexes and divider status for the point transform.
`default_nettype none
package hpt_pkg;
  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned NumRegs = 8;
  localparam int unsigned RegIdxW = 3;
  localparam int unsigned CfgW = 64;
  localparam int unsigned DataW = 32;
  localparam int unsigned NumComp = 3;

  typedef enum logic [RegIdxW-1:0] {
    REG_ROW0_C01 = 3'd0,
    REG_ROW0_C23 = 3'd1,
    REG_ROW1_C01 = 3'd2,
    REG_ROW1_C23 = 3'd3,
    REG_ROW2_C01 = 3'd4,
    REG_ROW2_C23 = 3'd5,
    REG_ROW3_C01 = 3'd6,
    REG_ROW3_C23 = 3'd7
  } reg_idx_e;

  // Status traveling down the divider chain alongside the operands.
  typedef struct packed {
    logic valid;
    logic w_zero;
    logic clip;
  } ctl_t;
endpackage
`default_nettype wire

[rtl/core/hpt_row.sv]
// Matrix row: four products, sum, floor shift and saturation, two pipeline stages.
`default_nettype none
module hpt_row #(
  parameter int unsigned FracBits = hpt_pkg::FracBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic [63:0] c01_i,
  input  wire logic [63:0] c23_i,
  input  wire logic signed [31:0] x_i,
  input  wire logic signed [31:0] y_i,
  input  wire logic signed [31:0] z_i,
  output logic signed [31:0] comp_o,
  output logic             sat_o
);
  logic signed [63:0] p_d [4];
  logic signed [63:0] p_q [4];
  logic signed [65:0] sum;
  logic signed [65:0] shr;
  logic signed [31:0] comp_d;
  logic               sat_d;

  always_comb begin
    p_d[0] = $signed(c01_i[31:0]) * x_i;
    p_d[1] = $signed(c01_i[63:32]) * y_i;
    p_d[2] = $signed(c23_i[31:0]) * z_i;
    p_d[3] = 64'($signed(c23_i[63:32])) <<< FracBits;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) p_q[i] <= p_d[i];
  end

  // Sum of exact products then one floor shift equals the split sum.
  always_comb begin
    sum = 66'(p_q[0]) + 66'(p_q[1]) + 66'(p_q[2]) + 66'(p_q[3]);
    shr = sum >>> FracBits;
    sat_d = 1'b0;
    comp_d = shr[31:0];
    if (shr > 66'sd2147483647) begin
      comp_d = 32'h7fffffff;
      sat_d = 1'b1;
    end else if (shr < -66'sd2147483648) begin
      comp_d = 32'h80000000;
      sat_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    comp_o <= comp_d;
    sat_o  <= sat_d;
  end
endmodule
`default_nettype wire

[rtl/core/hpt_div_cell.sv]
// Divider cell: one restoring step per coordinate, hands partial state to the next cell.
`default_nettype none
module hpt_div_cell #(
  parameter int unsigned QW = 49,
  parameter int unsigned Step = 0
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire hpt_pkg::ctl_t    ctl_i,
  input  wire logic [QW-1:0]    num_i [hpt_pkg::NumComp],
  input  wire logic [QW-1:0]    rem_i [hpt_pkg::NumComp],
  input  wire logic [QW-1:0]    quo_i [hpt_pkg::NumComp],
  input  wire logic [31:0]      den_i,
  input  wire logic [hpt_pkg::NumComp-1:0] neg_i,
  output hpt_pkg::ctl_t         ctl_o,
  output logic [QW-1:0]         num_o [hpt_pkg::NumComp],
  output logic [QW-1:0]         rem_o [hpt_pkg::NumComp],
  output logic [QW-1:0]         quo_o [hpt_pkg::NumComp],
  output logic [31:0]           den_o,
  output logic [hpt_pkg::NumComp-1:0] neg_o
);
  localparam int unsigned Bit = QW - 1 - Step;
  logic [QW:0] trial [hpt_pkg::NumComp];
  logic [QW-1:0] rem_d [hpt_pkg::NumComp];
  logic [QW-1:0] quo_d [hpt_pkg::NumComp];

  always_comb begin
    for (int i = 0; i < hpt_pkg::NumComp; i++) begin
      trial[i] = {rem_i[i], num_i[i][Bit]};
      quo_d[i] = quo_i[i];
      if (trial[i] >= (QW+1)'(den_i)) begin
        rem_d[i] = QW'(trial[i] - (QW+1)'(den_i));
        quo_d[i][Bit] = 1'b1;
      end else begin
        rem_d[i] = QW'(trial[i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '0;
    end else begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    num_o <= num_i;
    rem_o <= rem_d;
    quo_o <= quo_d;
    den_o <= den_i;
    neg_o <= neg_i;
  end
endmodule
`default_nettype wire

[rtl/core/homogeneous_point_transform.sv]
// Top level: matrix registers, row multipliers, divider cell chain and output stage.
//
// Usage: write the eight 64-bit matrix registers through cfg_we_i/cfg_idx_i/
// cfg_wdata_i while idle; row R columns A,B sit in register 2R+A/2, column A in
// the low word. Indexes beyond seven do not exist with a 3-bit index.
// Pulse start with point_x_i/y_i/z_i (signed Q16.16); busy is always low,
// so a point is taken in every cycle that start is high.
// Each result appears on out_x_o/out_y_o/out_z_o, w_was_zero_o and clipped_o
// for one cycle with done high. The path runs through the row multipliers
// (multiply and sum), the magnitude split, QW divider cells (QW = 33 + FRAC_BITS,
// one quotient bit per cell) and the sign and saturation stage.
// Throughput is one point per cycle; the divider chain sets the latency.
// Reset clears the valid chain and loads the identity matrix. The receiver
// cannot stall: results are shown once and not held.
`default_nettype none
module homogeneous_point_transform #(
  parameter int unsigned FRAC_BITS = hpt_pkg::FracBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic signed [31:0] point_x_i,
  input  wire logic signed [31:0] point_y_i,
  input  wire logic signed [31:0] point_z_i,
  input  wire logic        cfg_we_i,
  input  wire logic [hpt_pkg::RegIdxW-1:0] cfg_idx_i,
  input  wire logic [hpt_pkg::CfgW-1:0]    cfg_wdata_i,
  output logic             done,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic             w_was_zero_o,
  output logic             clipped_o
);
  localparam int unsigned QW = 33 + FRAC_BITS;
  localparam int unsigned NC = hpt_pkg::NumComp;
  localparam logic [63:0] One = 64'(1) << FRAC_BITS;

  logic [63:0] regs_q [hpt_pkg::NumRegs];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < hpt_pkg::NumRegs; i++) regs_q[i] <= '0;
      regs_q[hpt_pkg::REG_ROW0_C01] <= One;
      regs_q[hpt_pkg::REG_ROW1_C01] <= One << 32;
      regs_q[hpt_pkg::REG_ROW2_C23] <= One;
      regs_q[hpt_pkg::REG_ROW3_C23] <= One << 32;
    end else if (cfg_we_i) begin
      regs_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  assign busy = 1'b0;

  logic [1:0] vpipe_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vpipe_q <= '0;
    else vpipe_q <= {vpipe_q[0], start};
  end

  logic signed [31:0] comp [4];
  logic [3:0] rsat;
  for (genvar r = 0; r < 4; r++) begin : g_row
    hpt_row #(.FracBits(FRAC_BITS)) u_row (
      .clk_i (clk_i),
      .c01_i (regs_q[2*r]),
      .c23_i (regs_q[2*r+1]),
      .x_i   (point_x_i),
      .y_i   (point_y_i),
      .z_i   (point_z_i),
      .comp_o(comp[r]),
      .sat_o (rsat[r])
    );
  end

  // Split into magnitudes for the unsigned divider chain.
  hpt_pkg::ctl_t ctl [QW+1];
  logic [QW-1:0] num [QW+1][NC];
  logic [QW-1:0] rem [QW+1][NC];
  logic [QW-1:0] quo [QW+1][NC];
  logic [31:0] den [QW+1];
  logic [NC-1:0] neg [QW+1];
  logic [31:0] wabs;

  assign wabs = comp[3][31] ? 32'(-comp[3]) : comp[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl[0] <= '0;
    end else begin
      ctl[0].valid  <= vpipe_q[1];
      ctl[0].w_zero <= (comp[3] == '0);
      ctl[0].clip   <= |rsat;
    end
  end

  always_ff @(posedge clk_i) begin
    den[0] <= wabs;
    for (int i = 0; i < NC; i++) begin
      num[0][i] <= QW'(comp[i][31] ? 33'(-33'(comp[i])) : 33'(comp[i])) << FRAC_BITS;
      rem[0][i] <= '0;
      quo[0][i] <= '0;
      neg[0][i] <= comp[i][31] ^ comp[3][31];
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_cell
    hpt_div_cell #(.QW(QW), .Step(s)) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctl_i (ctl[s]),
      .num_i (num[s]),
      .rem_i (rem[s]),
      .quo_i (quo[s]),
      .den_i (den[s]),
      .neg_i (neg[s]),
      .ctl_o (ctl[s+1]),
      .num_o (num[s+1]),
      .rem_o (rem[s+1]),
      .quo_o (quo[s+1]),
      .den_o (den[s+1]),
      .neg_o (neg[s+1])
    );
  end

  // Sign and saturation.
  logic signed [31:0] res_d [NC];
  logic [NC-1:0] osat;
  always_comb begin
    for (int i = 0; i < NC; i++) begin
      osat[i] = 1'b0;
      res_d[i] = '0;
      if (!ctl[QW].w_zero) begin
        if (neg[QW][i]) begin
          if (quo[QW][i] > QW'(64'h80000000)) begin
            osat[i] = 1'b1;
            res_d[i] = 32'h80000000;
          end else begin
            res_d[i] = 32'(-quo[QW][i]);
          end
        end else if (quo[QW][i] > QW'(64'h7fffffff)) begin
          osat[i] = 1'b1;
          res_d[i] = 32'h7fffffff;
        end else begin
          res_d[i] = quo[QW][i][31:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done <= 1'b0;
    else done <= ctl[QW].valid;
  end

  always_ff @(posedge clk_i) begin
    out_x_o      <= res_d[0];
    out_y_o      <= res_d[1];
    out_z_o      <= res_d[2];
    w_was_zero_o <= ctl[QW].w_zero;
    clipped_o    <= ctl[QW].clip | (|osat);
  end

`ifndef SYNTHESIS
  a_busy_low: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");
  a_wzero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done && w_was_zero_o |-> out_x_o == 0 && out_y_o == 0 && out_z_o == 0)
    else $error("nonzero output with zero w");
  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> $past(ctl[QW].valid))
    else $error("done without item");
`endif
endmodule
`default_nettype wire

[test/homogeneous_point_transform_test.sv]
// Testbench: random and directed points through the 4x4 transform, checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module homogeneous_point_transform_test;
  import hpt_pkg::*;

  localparam int unsigned FB = FracBitsDef;
  localparam int unsigned LATENCY = 2 + 1 + (33 + FB) + 1;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic signed [31:0] x, y, z;
    logic w_zero, clip;
  } vertex_t;

  class vertex_scoreboard;
    logic [63:0] matrix[NumRegs];
    vertex_t pending[$];
    int errors;
    int checked;

    function void reset_matrix();
      for (int i = 0; i < NumRegs; i++) matrix[i] = '0;
      matrix[REG_ROW0_C01] = 64'd1 << FB;
      matrix[REG_ROW1_C01] = 64'd1 << (FB + 32);
      matrix[REG_ROW2_C23] = 64'd1 << FB;
      matrix[REG_ROW3_C23] = 64'd1 << (FB + 32);
    endfunction

    function logic signed [31:0] coeff(int row, int col);
      logic [63:0] r;
      r = matrix[row * 2 + col / 2];
      return (col % 2) ? r[63:32] : r[31:0];
    endfunction

    function logic signed [63:0] clamp32(logic signed [127:0] v, inout logic clip);
      if (v > 128'sd2147483647) begin
        clip = 1'b1;
        return 64'sd2147483647;
      end
      if (v < -128'sd2147483648) begin
        clip = 1'b1;
        return -64'sd2147483648;
      end
      return v[63:0];
    endfunction

    // Exact sum then arithmetic shift == floor of the fixed-point sum.
    function void note_point(logic signed [31:0] px, py, pz);
      logic signed [127:0] vec[4];
      logic signed [127:0] acc;
      logic signed [63:0] comp[4];
      logic signed [127:0] num;
      vertex_t e;
      e.clip = 1'b0;
      vec[0] = px;
      vec[1] = py;
      vec[2] = pz;
      vec[3] = 128'sd1 << FB;
      for (int r = 0; r < 4; r++) begin
        acc = 0;
        for (int c = 0; c < 4; c++) acc += 128'(coeff(r, c)) * vec[c];
        comp[r] = clamp32(acc >>> FB, e.clip);
      end
      if (comp[3] == 0) begin
        e.x = 0;
        e.y = 0;
        e.z = 0;
        e.w_zero = 1'b1;
      end else begin
        e.w_zero = 1'b0;
        num = 128'(comp[0]) <<< FB;
        e.x = 32'(clamp32(num / 128'(comp[3]), e.clip));
        num = 128'(comp[1]) <<< FB;
        e.y = 32'(clamp32(num / 128'(comp[3]), e.clip));
        num = 128'(comp[2]) <<< FB;
        e.z = 32'(clamp32(num / 128'(comp[3]), e.clip));
      end
      pending.push_back(e);
    endfunction

    function void check_result(vertex_t got);
      vertex_t e;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: x=%h y=%h z=%h", $time, got.x, got.y, got.z);
        return;
      end
      e = pending.pop_front();
      if (got.x !== e.x) begin
        errors++;
        $display("%0t: out_x expected %h actual %h", $time, e.x, got.x);
      end
      if (got.y !== e.y) begin
        errors++;
        $display("%0t: out_y expected %h actual %h", $time, e.y, got.y);
      end
      if (got.z !== e.z) begin
        errors++;
        $display("%0t: out_z expected %h actual %h", $time, e.z, got.z);
      end
      if (got.w_zero !== e.w_zero) begin
        errors++;
        $display("%0t: w_was_zero expected %b actual %b", $time, e.w_zero, got.w_zero);
      end
      if (got.clip !== e.clip) begin
        errors++;
        $display("%0t: clipped expected %b actual %b", $time, e.clip, got.clip);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] point_x_i = '0, point_y_i = '0, point_z_i = '0;
  logic cfg_we_i = 1'b0;
  logic [RegIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0] cfg_wdata_i = '0;
  logic done;
  logic signed [31:0] out_x_o, out_y_o, out_z_o;
  logic w_was_zero_o, clipped_o;

  vertex_scoreboard sb = new();
  int sent;
  int stall_cycles;
  int zero_w_seen, clip_seen;

  homogeneous_point_transform DUT (
    .clk_i, .rst_ni, .start, .busy, .point_x_i, .point_y_i, .point_z_i,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .done, .out_x_o, .out_y_o, .out_z_o,
    .w_was_zero_o, .clipped_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Sample both sides at the rising edge.
  always @(posedge clk_i) begin
    vertex_t got;
    if (rst_ni) begin
      if (start && !busy) begin
        sb.note_point(point_x_i, point_y_i, point_z_i);
        sent++;
      end
      if ((start && !busy) || done) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (done) begin
        got.x = out_x_o;
        got.y = out_y_o;
        got.z = out_z_o;
        got.w_zero = w_was_zero_o;
        got.clip = clipped_o;
        zero_w_seen += w_was_zero_o;
        clip_seen += clipped_o;
        sb.check_result(got);
      end
    end
  end

  always @(posedge clk_i) begin
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, sb.pending.size());
      $display("homogeneous_point_transform_test: FAIL");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [63:0] value);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = value;
    sb.matrix[idx] = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic drain();
    start = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  // Drive one point; holds start across back-to-back transfers.
  task automatic send_point(logic [31:0] px, py, pz, bit gaps);
    int gap;
    gap = 0;
    if (gaps) begin
      if ($urandom_range(0, 9) < 6) gap = 0;
      else if ($urandom_range(0, 9) < 8) gap = $urandom_range(1, 3);
      else gap = $urandom_range(5, 40);
    end
    if (gap != 0) begin
      start = 1'b0;
      point_x_i = $urandom;
      repeat (gap) @(negedge clk_i);
    end
    start = 1'b1;
    point_x_i = px;
    point_y_i = py;
    point_z_i = pz;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 2 * 65536 * 8)) - 65536 * 8);
      2: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'($urandom_range(0, 3) * 32'h2aaaaaaa)};
      default: return 32'($signed($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  function automatic logic [31:0] rand_coeff(int mode);
    case (mode)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 4 * 65536)) - 2 * 65536);
      2: return 32'h0;
      default: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
    endcase
  endfunction

  task automatic random_matrix(int mode);
    for (int i = 0; i < NumRegs; i++)
      write_reg(reg_idx_e'(i), {rand_coeff($urandom_range(0, 3) == 0 ? 0 : mode),
                                rand_coeff($urandom_range(0, 3) == 0 ? 0 : mode)});
  endtask

  localparam logic [31:0] ONE = 32'd1 << FB;
  localparam logic [31:0] MAXV = 32'h7fffffff;
  localparam logic [31:0] MINV = 32'h80000000;

  initial begin
    sb.reset_matrix();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: identity matrix with extreme points.
    send_point(0, 0, 0, 0);
    send_point(MAXV, MINV, 32'hffffffff, 0);
    send_point(MINV, MAXV, 1, 0);
    send_point(ONE, 32'hffff0000, 32'h00018000, 0);
    send_point(32'hffffffff, 32'hffffffff, 32'hffffffff, 0);
    drain();
    // w driven to zero by the point itself: w = z - 1.0
    write_reg(REG_ROW3_C23, {ONE, ONE});
    write_reg(REG_ROW3_C23, {32'hffff0000, ONE});
    send_point(ONE, ONE, ONE, 0);
    send_point(MAXV, 5, ONE, 0);
    send_point(3, 4, 32'h00010001, 0);
    send_point(MINV, MAXV, 0, 0);
    send_point(7, 7, MAXV, 0);
    drain();
    // Large coefficients: component saturation, zero w, tiny w divides.
    write_reg(REG_ROW0_C01, {MAXV, MAXV});
    write_reg(REG_ROW0_C23, {MINV, MAXV});
    write_reg(REG_ROW3_C01, 64'd0);
    write_reg(REG_ROW3_C23, {32'd1, 32'd0});
    send_point(MAXV, MAXV, 0, 0);
    send_point(MINV, MINV, MINV, 0);
    send_point(ONE, 0, 0, 0);
    drain();
    write_reg(REG_ROW3_C23, 64'd0);
    send_point(MAXV, MINV, MAXV, 0);
    send_point(1, 2, 3, 0);
    drain();
    write_reg(REG_ROW3_C23, {MINV, MINV});
    write_reg(REG_ROW3_C01, {MAXV, MINV});
    send_point(MAXV, MAXV, MAXV, 0);
    send_point(MINV, 0, MAXV, 0);
    send_point(ONE, ONE, ONE, 0);
    drain();

    // Random phases, each with a fresh matrix.
    for (int phase = 0; phase < 32; phase++) begin
      random_matrix(phase % 4);
      // Every few phases make w depend on z only, so w = 0 shows up often.
      if (phase % 3 == 0) begin
        write_reg(REG_ROW3_C01, 64'd0);
        write_reg(REG_ROW3_C23, {32'hffff0000, ONE});
      end
      for (int n = 0; n < 50; n++) begin
        logic [31:0] pz;
        pz = (phase % 3 == 0 && $urandom_range(0, 2) == 0) ? ONE : rand_coord($urandom_range(0, 3));
        send_point(rand_coord($urandom_range(0, 3)), rand_coord($urandom_range(0, 3)), pz,
                   phase % 5 != 4);
      end
      start = 1'b0;
      drain();
    end

    // Rows 0 and 3 back at the identity.
    write_reg(REG_ROW0_C01, 64'd1 << FB);
    write_reg(REG_ROW0_C23, 64'd0);
    write_reg(REG_ROW3_C23, 64'd1 << (FB + 32));
    write_reg(REG_ROW3_C01, 64'd0);
    send_point(MAXV, MINV, 1, 0);
    start = 1'b0;
    drain();

    $display("Covered %0d points, %0d results checked; %0d with zero w, %0d clipped.",
             sent, sb.checked, zero_w_seen, clip_seen);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("homogeneous_point_transform_test: PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
      $display("homogeneous_point_transform_test: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
